// ===== rtl/fir8_pkg.sv =====
`timescale 1ns / 1ps

package fir8_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int COEF_W       = 16;
   localparam int PROD_W       = SAMPLE_W + COEF_W;
   localparam int SUM_W        = 35;
   localparam int MAX_TAPS     = 8;
   localparam int TAPS_DEFAULT = 8;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 5;

   typedef logic signed [COEF_W-1:0] coef_array_type [MAX_TAPS];

   // per-cell control, shared by every cell of the row
   typedef struct packed {
      logic load;   // capture a new product
      logic acc;    // fold product into the partial sum chain
      logic clear;  // word closes a block: partial sums go to zero
   } cell_ctrl_type;

endpackage

// ===== rtl/fir8_req_if.sv =====
`timescale 1ns / 1ps

interface fir8_req_if;
   import fir8_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       block_end;

   modport source (output valid, sample, block_end, input ready);
   modport sink   (input valid, sample, block_end, output ready);

endinterface

// ===== rtl/fir8_rsp_if.sv =====
`timescale 1ns / 1ps

interface fir8_rsp_if;
   import fir8_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [SUM_W-1:0] filtered;
   logic                    last;

   modport source (output valid, filtered, last, input ready);
   modport sink   (input valid, filtered, last, output ready);

endinterface

// ===== rtl/fir8_csr.sv =====
`timescale 1ns / 1ps

module fir8_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fir8_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [fir8_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [fir8_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output fir8_pkg::coef_array_type         coef
);
   import fir8_pkg::*;

   localparam int IDX_W = $clog2(MAX_TAPS);

   logic signed [COEF_W-1:0] coef_ff [MAX_TAPS];
   logic [IDX_W-1:0]         idx;
   logic                     wr_en;

   assign idx        = csr_paddr[IDX_W+1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(CSR_DATA_W-COEF_W){1'b0}}, coef_ff[idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (wr_en) begin
         coef_ff[idx] <= csr_pwdata[COEF_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_TAPS; i++) begin
         coef[i] = coef_ff[i];
      end
   end

endmodule

// ===== rtl/fir8_cell.sv =====
`timescale 1ns / 1ps

module fir8_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  fir8_pkg::cell_ctrl_type             ctrl,
   input  logic signed [fir8_pkg::SAMPLE_W-1:0] sample,
   input  logic signed [fir8_pkg::COEF_W-1:0]   coef,
   input  logic signed [fir8_pkg::SUM_W-1:0]    sum_in,
   output logic signed [fir8_pkg::SUM_W-1:0]    tap_sum,
   output logic signed [fir8_pkg::SUM_W-1:0]    sum_out
);
   import fir8_pkg::*;

   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  sum_in_nxt;
   logic signed [SUM_W-1:0]  sum_ff;

   assign prod_in    = coef * sample;
   // product of this tap plus what the upstream neighbour has gathered
   assign tap_sum    = {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff} + sum_in;
   assign sum_in_nxt = ctrl.clear ? '0 : tap_sum;
   assign sum_out    = sum_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctrl.acc) begin
         sum_ff <= sum_in_nxt;
      end
   end

endmodule

// ===== rtl/fir_filter_8tap_unit.sv =====
`timescale 1ns / 1ps

// Streaming FIR filter, transposed direct form, TAPS taps (2..8). Each req word
// carries one signed Q1.15 sample and a block-end flag; each rsp word carries the
// full-precision Q9.26 sum of coef_j * x[n-j] (35 bits, no rounding) and a copy of
// the flag. The first TAPS-1 samples of a block give no rsp word; the word with
// block_end set closes the block and clears all history. Coefficients are signed
// Q5.11 registers coef_0..coef_7 at byte addresses 0,4,..,28 of the csr port; only
// the first TAPS are used. Write them only while the filter is idle. Throughput is
// one word per clock while no rsp word waits for rsp.ready. Two register stages: an
// accepted word loads the product registers in each cell, then, as the pipe advances,
// the adder chain and output register load and rsp valid rises.
// req.ready drops only while a finished rsp word is held waiting for rsp.ready.

module fir_filter_8tap_unit #(
   parameter int TAPS = fir8_pkg::TAPS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   fir8_req_if.sink                        req,
   fir8_rsp_if.source                      rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fir8_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fir8_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fir8_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import fir8_pkg::*;

   localparam int                CNT_W   = $clog2(TAPS);
   localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(TAPS - 1);

   coef_array_type          coef;
   cell_ctrl_type           ctrl;
   logic signed [SUM_W-1:0] chain [TAPS+1];
   logic signed [SUM_W-1:0] y;

   logic                    advance;
   logic                    accept;

   // warm-up count: samples seen in this block, saturating at TAPS-1
   logic [CNT_W-1:0]        cnt_ff;
   logic [CNT_W-1:0]        cnt_in;

   // product stage tags
   logic                    p_valid_ff;
   logic                    p_end_ff;
   logic                    p_emit_ff;

   // output register
   logic                    rsp_valid_ff;
   logic signed [SUM_W-1:0] rsp_filtered_ff;
   logic                    rsp_last_ff;

   fir8_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   // whole pipe moves when the output register is free or being drained
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && advance;
   assign req.ready = advance;

   assign ctrl.load  = accept;
   assign ctrl.acc   = advance && p_valid_ff;
   assign ctrl.clear = p_end_ff;

   assign chain[TAPS] = '0;

   // cell k keeps the partial sum for taps k..TAPS-1; sums flow toward cell 0
   for (genvar k = 0; k < TAPS; k++) begin : g_cell
      if (k == 0) begin : g_head
         fir8_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (ctrl),
            .sample  (req.sample),
            .coef    (coef[k]),
            .sum_in  (chain[k+1]),
            .tap_sum (y),
            .sum_out (chain[k])
         );
      end else begin : g_body
         fir8_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (ctrl),
            .sample  (req.sample),
            .coef    (coef[k]),
            .sum_in  (chain[k+1]),
            .tap_sum (),
            .sum_out (chain[k])
         );
      end
   end

   always_comb begin
      if (req.block_end) begin
         cnt_in = '0;
      end else if (cnt_ff == CNT_MAX) begin
         cnt_in = cnt_ff;
      end else begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            cnt_ff <= cnt_in;
         end
         if (advance) begin
            p_valid_ff   <= accept;
            rsp_valid_ff <= p_valid_ff && p_emit_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_end_ff  <= req.block_end;
         p_emit_ff <= (cnt_ff == CNT_MAX);
      end
      if (ctrl.acc) begin
         rsp_filtered_ff <= y;
         rsp_last_ff     <= p_end_ff;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.filtered = rsp_filtered_ff;
   assign rsp.last     = rsp_last_ff;

   // count never runs past saturation
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("warm-up count out of range");

   // a block end restarts the warm-up
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req.block_end |=> cnt_ff == '0)
      else $error("block end did not clear warm-up count");

   // a new result only appears from a warmed-up word in the product stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(p_valid_ff && p_emit_ff && advance))
      else $error("result without a warmed-up source word");

endmodule
